@@ hw/rtl/bb3_pkg.sv @@
`timescale 1ns / 1ps

package bb3_pkg;

	localparam int PIXEL_BITS     = 16;
	localparam int SUM_BITS       = PIXEL_BITS + 4;
	localparam int COL_OUT_BITS   = 10;
	localparam int ROW_BITS       = 12;
	localparam int MAX_HEIGHT     = 4096;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int RESET_SIZE     = 640;

	localparam int CFG_WIDTH_BITS  = 11;
	localparam int CFG_HEIGHT_BITS = 13;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_IDX_BITS    = 1;

	localparam int IN_TDATA_BITS  = 16;
	localparam int OUT_FIELD_BITS = PIXEL_BITS + COL_OUT_BITS + ROW_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	// (x * DIV9_MULT) >> DIV9_SHIFT == x / 9 for every x below 2**(SUM_BITS+1)
	localparam int DIV9_SHIFT = SUM_BITS + 3;
	localparam int MULT_BITS  = SUM_BITS;
	localparam logic [MULT_BITS-1:0] DIV9_MULT =
		MULT_BITS'((64'd1 << DIV9_SHIFT) / 64'd9 + 64'd1);
	localparam int PROD_BITS = SUM_BITS + MULT_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                    last;
		logic [COL_OUT_BITS-1:0] col;
		logic [ROW_BITS-1:0]     row;
	} pos_tag_t;

endpackage

@@ hw/rtl/bb3_window.sv @@
`timescale 1ns / 1ps

module bb3_window #(
	parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
	parameter int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bb3_pkg::PIXEL_BITS-1:0]   in_pixel,
	input  logic [ADDR_BITS-1:0]             in_addr,
	input  logic                             in_emit,
	input  bb3_pkg::pos_tag_t                in_tag,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bb3_pkg::SUM_BITS-1:0]     out_sum,
	output bb3_pkg::pos_tag_t                out_tag
);
	import bb3_pkg::*;

	// each entry holds {upper row, middle row} for one column
	logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];

	logic                    v_s1;
	logic [PIXEL_BITS-1:0]   pix_s1;
	logic [ADDR_BITS-1:0]    addr_s1;
	logic                    emit_s1;
	pos_tag_t                tag_s1;
	logic [2*PIXEL_BITS-1:0] rd_s1;

	logic [PIXEL_BITS-1:0]   win_q [6];

	logic                    v_s2;
	logic [SUM_BITS-1:0]     sum_s2;
	pos_tag_t                tag_s2;

	logic                    rdy2;
	logic                    adv1;
	logic                    acc;
	logic [PIXEL_BITS-1:0]   up;
	logic [PIXEL_BITS-1:0]   mid;
	logic [SUM_BITS-1:0]     sum;

	assign rdy2     = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy2;
	assign acc      = in_valid && in_ready;
	assign adv1     = v_s1 && rdy2;
	assign up       = rd_s1[2*PIXEL_BITS-1:PIXEL_BITS];
	assign mid      = rd_s1[PIXEL_BITS-1:0];

	always_comb begin
		sum = SUM_BITS'(up) + SUM_BITS'(mid) + SUM_BITS'(pix_s1);
		for (int i = 0; i < 6; i++) begin
			sum = sum + SUM_BITS'(win_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[in_addr];
		end
		if (adv1) begin
			mem[addr_s1] <= {mid, pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && emit_s1;
			end
			if (adv1) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= up;
				win_q[4] <= mid;
				win_q[5] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= in_pixel;
			addr_s1 <= in_addr;
			emit_s1 <= in_emit;
			tag_s1  <= in_tag;
		end
		if (adv1) begin
			sum_s2 <= sum;
			tag_s2 <= tag_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_sum   = sum_s2;
	assign out_tag   = tag_s2;

endmodule

@@ hw/rtl/bb3_div9.sv @@
`timescale 1ns / 1ps

module bb3_div9 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bb3_pkg::SUM_BITS-1:0]   in_sum,
	input  bb3_pkg::pos_tag_t              in_tag,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bb3_pkg::PIXEL_BITS-1:0] out_value,
	output bb3_pkg::pos_tag_t              out_tag
);
	import bb3_pkg::*;

	logic                  v_s3;
	logic [PIXEL_BITS-1:0] value_s3;
	pos_tag_t              tag_s3;
	logic [SUM_BITS-1:0]   rounded;
	logic [PROD_BITS-1:0]  prod;

	// nine-tap sum + 4 stays below 2**SUM_BITS
	assign rounded  = in_sum + SUM_BITS'(4);
	assign prod     = PROD_BITS'(rounded) * PROD_BITS'(DIV9_MULT);
	assign in_ready = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s3 <= prod[DIV9_SHIFT +: PIXEL_BITS];
			tag_s3   <= in_tag;
		end
	end

	assign out_valid = v_s3;
	assign out_value = value_s3;
	assign out_tag   = tag_s3;

endmodule

@@ hw/rtl/box_blur_3x3_stream.sv @@
`timescale 1ns / 1ps

// 3x3 box filter over a raster-order grayscale stream.
// Input: one pixel per item on s_axis (16-bit unsigned, value/65535).
// Output: one item per interior pixel on m_axis: the rounded mean of its
// 3x3 neighborhood plus its column and row; tlast marks the last interior
// pixel of the frame. Border pixels are absorbed and give no item.
// Throughput: one pixel per clock while m_axis_tready holds, with no gaps between frames.
// m_axis_tvalid rises once the closing pixel has passed the registered stages
// (input register with line store read, nine-tap sum, multiply by 1/9).
// Two line stores live in one MAX_WIDTH x 32 memory, read and written once
// per item at the current column.
// Back-pressure: each stage stalls only when it is full and the next one
// is stalled, so s_axis_tready stays high while bubbles remain.
// Reset: counters at frame start, width 640 (MAX_WIDTH if less), height
// 640, window cleared; line store contents are not cleared (only rows
// already written are read into a result). Writing either register
// restarts the frame; write only while no item is in flight.
module box_blur_3x3_stream #(
	parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [15:0] pixel_in
	input  logic [bb3_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] blurred_value, [25:16] center_col, [37:26] center_row, rest 0
	output logic [bb3_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_we,
	input  logic [bb3_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bb3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import bb3_pkg::*;

	localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WLAST_RST = ((RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE) - 1;
	localparam int HLAST_RST = RESET_SIZE - 1;

	logic [ADDR_BITS-1:0] col_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [ADDR_BITS-1:0] wlast_q;
	logic [ROW_BITS-1:0]  hlast_q;

	logic [CFG_WIDTH_BITS-1:0]  wcfg;
	logic [CFG_HEIGHT_BITS-1:0] hcfg;
	logic [ADDR_BITS-1:0]       wlast_d;
	logic [ROW_BITS-1:0]        hlast_d;

	logic                 acc;
	logic                 emit;
	pos_tag_t             tag;
	logic [ADDR_BITS-1:0] col_m1;

	logic                 sum_valid;
	logic                 sum_ready;
	logic [SUM_BITS-1:0]  sum;
	pos_tag_t             sum_tag;
	logic [PIXEL_BITS-1:0] value;
	pos_tag_t             out_tag;

	assign wcfg = cfg_data[CFG_WIDTH_BITS-1:0];
	assign hcfg = cfg_data[CFG_HEIGHT_BITS-1:0];

	always_comb begin
		if (wcfg < CFG_WIDTH_BITS'(3)) begin
			wlast_d = ADDR_BITS'(2);
		end else if (32'(wcfg) > 32'(MAX_WIDTH)) begin
			wlast_d = ADDR_BITS'(MAX_WIDTH - 1);
		end else begin
			wlast_d = ADDR_BITS'(wcfg - CFG_WIDTH_BITS'(1));
		end
		if (hcfg < CFG_HEIGHT_BITS'(3)) begin
			hlast_d = ROW_BITS'(2);
		end else if (hcfg > CFG_HEIGHT_BITS'(MAX_HEIGHT)) begin
			hlast_d = ROW_BITS'(MAX_HEIGHT - 1);
		end else begin
			hlast_d = ROW_BITS'(hcfg - CFG_HEIGHT_BITS'(1));
		end
	end

	assign acc    = s_axis_tvalid && s_axis_tready;
	assign emit   = (col_q >= ADDR_BITS'(2)) && (row_q >= ROW_BITS'(2));
	assign col_m1 = col_q - ADDR_BITS'(1);

	always_comb begin
		tag.last = (col_q == wlast_q) && (row_q == hlast_q);
		tag.col  = COL_OUT_BITS'(col_m1);
		tag.row  = row_q - ROW_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			wlast_q <= ADDR_BITS'(WLAST_RST);
			hlast_q <= ROW_BITS'(HLAST_RST);
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  wlast_q <= wlast_d;
				REG_IMAGE_HEIGHT: hlast_q <= hlast_d;
				default:          ;
			endcase
		end else if (acc) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + ADDR_BITS'(1);
			end
		end
	end

	bb3_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.ADDR_BITS (ADDR_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pixel  (s_axis_tdata[PIXEL_BITS-1:0]),
		.in_addr   (col_q),
		.in_emit   (emit),
		.in_tag    (tag),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.out_sum   (sum),
		.out_tag   (sum_tag)
	);

	bb3_div9 u_div9 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.in_sum    (sum),
		.in_tag    (sum_tag),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (value),
		.out_tag   (out_tag)
	);

	assign m_axis_tdata = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}},
		out_tag.row, out_tag.col, value};
	assign m_axis_tlast = out_tag.last;

endmodule

@@ dv/box_blur_3x3_stream_test.sv @@
`timescale 1ns / 1ps

module box_blur_3x3_stream_test;

	import bb3_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PIXELS = 600;

	typedef struct packed {
		logic [PIXEL_BITS-1:0]   value;
		logic [COL_OUT_BITS-1:0] col;
		logic [ROW_BITS-1:0]     row;
		logic                    last;
	} blur_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      cfg_we = 1'b0;
	cfg_reg_t                  cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// predictor state
	logic [PIXEL_BITS-1:0]      line_upper [DEF_MAX_WIDTH];
	logic [PIXEL_BITS-1:0]      line_middle [DEF_MAX_WIDTH];
	logic [PIXEL_BITS-1:0]      win_cols [6];
	logic [COL_OUT_BITS-1:0]    pred_col = '0;
	logic [ROW_BITS-1:0]        pred_row = '0;
	logic [CFG_WIDTH_BITS-1:0]  pred_width = CFG_WIDTH_BITS'(RESET_SIZE);
	logic [CFG_HEIGHT_BITS-1:0] pred_height = CFG_HEIGHT_BITS'(RESET_SIZE);

	logic [PIXEL_BITS-1:0] pixel_queue [$];
	blur_result_t          blur_expected [$];

	logic pix_taken = 1'b0;
	logic res_taken = 1'b0;
	int   send_wait = 0;
	int   recv_wait = 0;
	int   send_gap_max = 12;
	int   recv_gap_max = 12;
	int   cycle_count = 0;
	int   fail_count = 0;
	int   pixel_count = 0;
	int   result_count = 0;
	int   frame_ends = 0;
	int   reg_writes = 0;

	box_blur_3x3_stream i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int clamp_dim(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("mismatch: %s", msg);
	endtask

	task automatic blur_predict(input logic [PIXEL_BITS-1:0] pix);
		int w, h, c, r, i;
		int unsigned total;
		logic [PIXEL_BITS-1:0] up, mid;
		blur_result_t res;
		w = clamp_dim(pred_width, 3, DEF_MAX_WIDTH);
		h = clamp_dim(pred_height, 3, MAX_HEIGHT);
		c = pred_col;
		r = pred_row;
		if (c >= w) c = 0;
		if (r >= h) r = 0;
		up = line_upper[c];
		mid = line_middle[c];
		if (c >= 2 && r >= 2) begin
			total = up + mid + pix;
			for (i = 0; i < 6; i++) total += win_cols[i];
			res.value = PIXEL_BITS'((total + 4) / 9);
			res.col = COL_OUT_BITS'(c - 1);
			res.row = ROW_BITS'(r - 1);
			res.last = (c == w - 1) && (r == h - 1);
			blur_expected.push_back(res);
		end
		line_upper[c] = mid;
		line_middle[c] = pix;
		for (i = 0; i < 3; i++) win_cols[i] = win_cols[i + 3];
		win_cols[3] = up;
		win_cols[4] = mid;
		win_cols[5] = pix;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		pred_col = COL_OUT_BITS'(c);
		pred_row = ROW_BITS'(r);
	endtask

	// monitor, checker and predictor
	always @(posedge clk) begin
		blur_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
		pix_taken <= s_axis_tvalid && s_axis_tready;
		res_taken <= m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (m_axis_tlast) frame_ends++;
			if (blur_expected.size() == 0) begin
				note_failure($sformatf("unexpected item tdata=%h tlast=%b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = blur_expected.pop_front();
				if (m_axis_tdata[PIXEL_BITS-1:0] !== want.value ||
					m_axis_tdata[PIXEL_BITS +: COL_OUT_BITS] !== want.col ||
					m_axis_tdata[PIXEL_BITS+COL_OUT_BITS +: ROW_BITS] !== want.row ||
					m_axis_tlast !== want.last) begin
					note_failure($sformatf(
						"exp val=%0d col=%0d row=%0d last=%b, got val=%0d col=%0d row=%0d last=%b",
						want.value, want.col, want.row, want.last,
						m_axis_tdata[PIXEL_BITS-1:0],
						m_axis_tdata[PIXEL_BITS +: COL_OUT_BITS],
						m_axis_tdata[PIXEL_BITS+COL_OUT_BITS +: ROW_BITS],
						m_axis_tlast));
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			pixel_count++;
			blur_predict(s_axis_tdata[PIXEL_BITS-1:0]);
		end
		if (arst_n && cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				pred_width = cfg_data[CFG_WIDTH_BITS-1:0];
			end else begin
				pred_height = cfg_data[CFG_HEIGHT_BITS-1:0];
			end
			pred_col = '0;
			pred_row = '0;
		end
	end

	// pixel driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && pix_taken) send_wait = $urandom_range(0, send_gap_max);
			if (!s_axis_tvalid || pix_taken) begin
				if (send_wait == 0 && pixel_queue.size() > 0) begin
					s_axis_tdata <= pixel_queue.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (send_wait > 0) send_wait--;
				end
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (res_taken) recv_wait = $urandom_range(0, recv_gap_max);
			if (recv_wait > 0) begin
				m_axis_tready <= 1'b0;
				recv_wait--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(value);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	task automatic load_pixels(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				pixel_queue.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
			end else begin
				pixel_queue.push_back(PIXEL_BITS'($urandom));
			end
		end
	endtask

	// checked at the rising edge, once the driver's updates have landed
	task automatic drain();
		while (pixel_queue.size() > 0 || s_axis_tvalid || blur_expected.size() > 0)
			@(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int i, w_sel, h_sel, w_eff, h_eff, n, random_pixels, phase;
		for (i = 0; i < 6; i++) win_cols[i] = '0;
		random_pixels = 0;
		phase = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// smallest frame: all white, then a single white pixel in the middle
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		repeat (9) pixel_queue.push_back(16'hFFFF);
		for (i = 0; i < 9; i++) pixel_queue.push_back(i == 4 ? 16'hFFFF : 16'h0000);
		settle();

		// sizes below the minimum clamp to 3
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		load_pixels(30);
		settle();

		// oversized width clamps to the line store depth
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_IMAGE_HEIGHT, 3);
		load_pixels(20);
		settle();

		// widest and tallest legal settings, restarted mid row with an oversized height
		write_reg(REG_IMAGE_WIDTH, DEF_MAX_WIDTH);
		write_reg(REG_IMAGE_HEIGHT, MAX_HEIGHT);
		load_pixels(20);
		settle();
		write_reg(REG_IMAGE_HEIGHT, 8191);
		write_reg(REG_IMAGE_WIDTH, 3);
		load_pixels(120);
		settle();

		while (random_pixels < RANDOM_PIXELS) begin
			w_sel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			h_sel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			case ($urandom_range(0, 2))
				0: begin
					write_reg(REG_IMAGE_WIDTH, w_sel);
					write_reg(REG_IMAGE_HEIGHT, h_sel);
				end
				1: write_reg(REG_IMAGE_WIDTH, w_sel);
				default: write_reg(REG_IMAGE_HEIGHT, h_sel);
			endcase
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			w_eff = clamp_dim(pred_width, 3, DEF_MAX_WIDTH);
			h_eff = clamp_dim(pred_height, 3, MAX_HEIGHT);
			if (w_eff * h_eff > 200) h_eff = 200 / w_eff;
			n = w_eff * h_eff * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0) n -= $urandom_range(1, w_eff);
			if (phase == 2) begin
				// hold the stream until the output side is empty
				load_pixels(n / 2);
				drain();
				load_pixels(n - n / 2);
			end else begin
				load_pixels(n);
			end
			random_pixels += n;
			phase++;
			settle();
		end

		$display("%0d pixels in %0d phases, %0d register writes", pixel_count, phase + 5,
			reg_writes);
		$display("%0d blurred items checked, %0d frame ends seen", result_count, frame_ends);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d failures", fail_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
